@@ hdl/bpr_pkg.sv @@
// ----------------------------------------------------------------------------
// bpr_pkg
// Shared types, constants and helpers for the BMP pixel to RGB565 streamer.
// ----------------------------------------------------------------------------
package bpr_pkg;

   localparam int PALETTE_DEPTH = 256;
   localparam int COORD_BITS    = 13;
   localparam int PAL_AW        = $clog2(PALETTE_DEPTH);
   localparam int SUM_W         = 16;
   localparam logic [SUM_W-1:0] COORD_MASK = SUM_W'((32'd1 << COORD_BITS) - 32'd1);

   // request modes
   localparam logic [1:0] MODE_LOAD  = 2'd0;
   localparam logic [1:0] MODE_START = 2'd1;
   localparam logic [1:0] MODE_DATA  = 2'd2;

   // pixel formats
   localparam logic [1:0] FMT_PAL  = 2'd0;
   localparam logic [1:0] FMT_565  = 2'd1;
   localparam logic [1:0] FMT_888  = 2'd2;
   localparam logic [1:0] FMT_8888 = 2'd3;

   // register indexes
   localparam logic [2:0] REG_FORMAT   = 3'd0;
   localparam logic [2:0] REG_ORIGIN_X = 3'd1;
   localparam logic [2:0] REG_ORIGIN_Y = 3'd2;
   localparam logic [2:0] REG_WIDTH    = 3'd3;
   localparam logic [2:0] REG_HEIGHT   = 3'd4;

   // result kinds
   localparam logic KIND_CURSOR = 1'b0;
   localparam logic KIND_PIXEL  = 1'b1;

   typedef struct packed {
      logic [1:0]  pixel_format;
      logic [11:0] origin_x;
      logic [11:0] origin_y;
      logic [12:0] image_width;
      logic [13:0] image_height;
   } cfg_type;

   typedef struct packed {
      logic        cursor;
      logic        pixel;
      logic        lut;
      logic        lut_ok;
      logic        raw;
      logic [23:0] held;
      logic [12:0] column;
      logic [12:0] row;
   } item_type;

   function automatic logic [13:0] rows_eff(input logic [13:0] height);
      logic [13:0] mag;
      mag = height[13] ? 14'(~height + 14'd1) : height;
      return (mag == '0) ? 14'd1 : mag;
   endfunction

   function automatic logic [15:0] to565(input logic [23:0] c);
      return {c[23:19], c[15:10], c[7:3]};
   endfunction

endpackage

@@ hdl/bpr_ram.sv @@
// ----------------------------------------------------------------------------
// bpr_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module bpr_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/bpr_front.sv @@
// ----------------------------------------------------------------------------
// bpr_front
// Request intake: palette memory, byte assembler and cursor walk.
// ----------------------------------------------------------------------------
module bpr_front (
   input  logic              clock,
   input  logic              reset,
   input  bpr_pkg::cfg_type  cfg,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [1:0]        req_mode,
   input  logic [7:0]        req_data_byte,
   input  logic [7:0]        req_palette_index,
   input  logic [23:0]       req_palette_color,
   input  logic              s1_take,
   output logic              s1_valid,
   output bpr_pkg::item_type s1_item,
   output logic [23:0]       lut_data
);

   logic              acc;
   logic [12:0]       column_ff, column_in;
   logic [12:0]       row_ff, row_in;
   logic [1:0]        phase_ff, phase_in;
   logic [23:0]       held_ff, held_in;
   logic              s1_valid_ff, s1_valid_in;
   bpr_pkg::item_type s1_item_ff, s1_item_in;
   logic [23:0]       held_ins;
   logic [12:0]       width_eff;
   logic [13:0]       rows;
   logic [13:0]       row_inc;
   logic              wrap;
   logic [12:0]       col_use, row_use;
   logic              s1_load;
   logic              pal_wr;

   assign s1_load    = !s1_valid_ff || s1_take;
   assign req_tready = s1_load;
   assign acc        = req_tvalid && req_tready;

   assign width_eff = (cfg.image_width == '0) ? 13'd1 : cfg.image_width;
   assign rows      = bpr_pkg::rows_eff(cfg.image_height);
   assign row_inc   = {1'b0, row_ff} + 14'd1;
   assign wrap      = column_ff >= width_eff;
   assign col_use   = wrap ? 13'd0 : column_ff;
   assign row_use   = wrap ? ((row_inc >= rows) ? 13'd0 : row_inc[12:0]) : row_ff;

   always_comb begin
      held_ins = held_ff;
      unique case (phase_ff)
         2'd0: held_ins[7:0]   = req_data_byte;
         2'd1: held_ins[15:8]  = req_data_byte;
         2'd2: held_ins[23:16] = req_data_byte;
         default: held_ins = held_ff;
      endcase
   end

   always_comb begin
      column_in   = column_ff;
      row_in      = row_ff;
      phase_in    = phase_ff;
      held_in     = held_ff;
      s1_valid_in = s1_load ? 1'b0 : s1_valid_ff;
      s1_item_in  = s1_item_ff;
      pal_wr      = 1'b0;
      if (acc) begin
         s1_item_in.cursor = 1'b0;
         s1_item_in.pixel  = 1'b0;
         s1_item_in.lut    = 1'b0;
         s1_item_in.lut_ok = 1'b0;
         s1_item_in.raw    = 1'b0;
         s1_item_in.held   = held_ins;
         s1_item_in.column = col_use;
         s1_item_in.row    = row_use;
         unique case (req_mode)
            bpr_pkg::MODE_LOAD: begin
               pal_wr = 32'(req_palette_index) < bpr_pkg::PALETTE_DEPTH;
            end
            bpr_pkg::MODE_START: begin
               column_in         = '0;
               row_in            = '0;
               phase_in          = '0;
               held_in           = '0;
               s1_valid_in       = 1'b1;
               s1_item_in.cursor = 1'b1;
               s1_item_in.column = '0;
               s1_item_in.row    = '0;
            end
            bpr_pkg::MODE_DATA: begin
               if (phase_ff < cfg.pixel_format) begin
                  phase_in = phase_ff + 2'd1;
                  held_in  = held_ins;
               end else begin
                  phase_in          = '0;
                  held_in           = '0;
                  column_in         = col_use + 13'd1;
                  row_in            = row_use;
                  s1_valid_in       = 1'b1;
                  s1_item_in.cursor = wrap;
                  s1_item_in.pixel  = 1'b1;
                  s1_item_in.lut    = cfg.pixel_format == bpr_pkg::FMT_PAL;
                  s1_item_in.lut_ok = 32'(req_data_byte) < bpr_pkg::PALETTE_DEPTH;
                  s1_item_in.raw    = cfg.pixel_format == bpr_pkg::FMT_565;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff   <= '0;
         row_ff      <= '0;
         phase_ff    <= '0;
         held_ff     <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         column_ff   <= column_in;
         row_ff      <= row_in;
         phase_ff    <= phase_in;
         held_ff     <= held_in;
         s1_valid_ff <= s1_valid_in;
      end
      s1_item_ff <= s1_item_in;
   end

   bpr_ram #(
      .WIDTH(24),
      .DEPTH(bpr_pkg::PALETTE_DEPTH)
   ) u_palette (
      .clock  (clock),
      .wr_en  (acc && pal_wr),
      .wr_addr(req_palette_index[bpr_pkg::PAL_AW-1:0]),
      .wr_data(req_palette_color),
      .rd_en  (acc),
      .rd_addr(req_data_byte[bpr_pkg::PAL_AW-1:0]),
      .rd_data(lut_data)
   );

   assign s1_valid = s1_valid_ff;
   assign s1_item  = s1_item_ff;

   a_start_clears: assert property (@(posedge clock) disable iff (reset)
      (acc && req_mode == bpr_pkg::MODE_START) |=>
      (column_ff == '0 && row_ff == '0 && phase_ff == '0))
      else $error("start request did not clear cursor");

endmodule

@@ hdl/bpr_emit.sv @@
// ----------------------------------------------------------------------------
// bpr_emit
// Color conversion, screen coordinates and the result register.
// ----------------------------------------------------------------------------
module bpr_emit (
   input  logic              clock,
   input  logic              reset,
   input  bpr_pkg::cfg_type  cfg,
   input  logic              s1_valid,
   input  bpr_pkg::item_type s1_item,
   input  logic [23:0]       lut_data,
   output logic              s1_take,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [12:0]       rsp_x,
   output logic [12:0]       rsp_y,
   output logic [15:0]       rsp_pixel,
   output logic              rsp_kind,
   output logic              rsp_last
);

   logic        out_valid_ff, out_valid_in;
   logic        out_kind_ff, out_kind_in;
   logic        out_last_ff, out_last_in;
   logic        pend_ff, pend_in;
   logic [12:0] out_x_ff, out_x_in;
   logic [12:0] out_y_ff, out_y_in;
   logic [15:0] out_px_ff, out_px_in;
   logic [15:0] pend_px_ff, pend_px_in;
   logic        out_free;
   logic [23:0] color;
   logic [15:0] px;
   logic [bpr_pkg::SUM_W-1:0] x_sum, y_sum;

   assign out_free = !out_valid_ff || (rsp_tready && !pend_ff);
   assign s1_take  = s1_valid && out_free;

   assign color = s1_item.lut ? (s1_item.lut_ok ? lut_data : 24'd0) : s1_item.held;
   assign px    = s1_item.raw ? s1_item.held[15:0] : bpr_pkg::to565(color);

   assign x_sum = (bpr_pkg::SUM_W'(cfg.origin_x) + bpr_pkg::SUM_W'(s1_item.column))
                  & bpr_pkg::COORD_MASK;
   assign y_sum = (cfg.image_height[13]
                  ? bpr_pkg::SUM_W'(cfg.origin_y) + bpr_pkg::SUM_W'(s1_item.row)
                  : bpr_pkg::SUM_W'(cfg.origin_y)
                    + bpr_pkg::SUM_W'(bpr_pkg::rows_eff(cfg.image_height))
                    - bpr_pkg::SUM_W'(1) - bpr_pkg::SUM_W'(s1_item.row))
                  & bpr_pkg::COORD_MASK;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_kind_in  = out_kind_ff;
      out_last_in  = out_last_ff;
      pend_in      = pend_ff;
      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      out_px_in    = out_px_ff;
      pend_px_in   = pend_px_ff;
      priority if (s1_take) begin
         out_valid_in = 1'b1;
         out_x_in     = x_sum[12:0];
         out_y_in     = y_sum[12:0];
         pend_px_in   = px;
         if (s1_item.cursor) begin
            out_kind_in = bpr_pkg::KIND_CURSOR;
            out_px_in   = '0;
            out_last_in = !s1_item.pixel;
            pend_in     = s1_item.pixel;
         end else begin
            out_kind_in = bpr_pkg::KIND_PIXEL;
            out_px_in   = px;
            out_last_in = 1'b1;
            pend_in     = 1'b0;
         end
      end else if (out_valid_ff && rsp_tready && pend_ff) begin
         out_kind_in = bpr_pkg::KIND_PIXEL;
         out_px_in   = pend_px_ff;
         out_last_in = 1'b1;
         pend_in     = 1'b0;
      end else if (out_valid_ff && rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         pend_ff      <= pend_in;
      end
      out_kind_ff <= out_kind_in;
      out_last_ff <= out_last_in;
      out_x_ff    <= out_x_in;
      out_y_ff    <= out_y_in;
      out_px_ff   <= out_px_in;
      pend_px_ff  <= pend_px_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_x      = out_x_ff;
   assign rsp_y      = out_y_ff;
   assign rsp_pixel  = out_px_ff;
   assign rsp_kind   = out_kind_ff;
   assign rsp_last   = out_last_ff;

   a_pend_shape: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (out_valid_ff && out_kind_ff == bpr_pkg::KIND_CURSOR && !out_last_ff))
      else $error("pending pixel without leading cursor result");

   a_pend_follow: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && rsp_tready && pend_ff) |=>
      (out_valid_ff && out_kind_ff == bpr_pkg::KIND_PIXEL && out_last_ff))
      else $error("pixel did not follow cursor result");

   a_take_fills: assert property (@(posedge clock) disable iff (reset)
      s1_take |=> out_valid_ff)
      else $error("taken request produced no result");

endmodule

@@ hdl/bmp_pixel_to_rgb565_streamer.sv @@
// ----------------------------------------------------------------------------
// bmp_pixel_to_rgb565_streamer
// BMP pixel-data bytes in, RGB565 pixel writes and set-cursor commands out.
// ----------------------------------------------------------------------------
// Takes one request per cycle unless stalled. A data byte that completes a
// pixel gives one pixel write, or a set-cursor command followed by the pixel
// write when the pixel opens a new row; a start request gives one set-cursor
// command. Results leave one per cycle while rsp_tready is high; a row change
// stalls later items until its pixel write leaves. A request is registered with
// the palette read, then in the result register. No clearing pass is needed
// after reset; palette entries are undefined until loaded. Config writes are
// taken any cycle but must only be issued while the block is idle.
// ----------------------------------------------------------------------------
module bmp_pixel_to_rgb565_streamer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // data_byte, palette_index, palette_color
   input  logic [1:0]  req_tuser,  // mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,  // cursor_x, cursor_y, pixel, zero pad
   output logic        rsp_tuser,  // kind
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [13:0] csr_data
);

   bpr_pkg::cfg_type  cfg_ff, cfg_in;
   logic              s1_valid;
   logic              s1_take;
   bpr_pkg::item_type s1_item;
   logic [23:0]       lut_data;
   logic [12:0]       rsp_x, rsp_y;
   logic [15:0]       rsp_pixel;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            bpr_pkg::REG_FORMAT:   cfg_in.pixel_format = csr_data[1:0];
            bpr_pkg::REG_ORIGIN_X: cfg_in.origin_x     = csr_data[11:0];
            bpr_pkg::REG_ORIGIN_Y: cfg_in.origin_y     = csr_data[11:0];
            bpr_pkg::REG_WIDTH:    cfg_in.image_width  = csr_data[12:0];
            bpr_pkg::REG_HEIGHT:   cfg_in.image_height = csr_data;
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pixel_format <= bpr_pkg::FMT_888;
         cfg_ff.origin_x     <= '0;
         cfg_ff.origin_y     <= '0;
         cfg_ff.image_width  <= 13'd1;
         cfg_ff.image_height <= 14'd1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   bpr_front u_front (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_mode         (req_tuser),
      .req_data_byte    (req_tdata[7:0]),
      .req_palette_index(req_tdata[15:8]),
      .req_palette_color(req_tdata[39:16]),
      .s1_take          (s1_take),
      .s1_valid         (s1_valid),
      .s1_item          (s1_item),
      .lut_data         (lut_data)
   );

   bpr_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .s1_valid  (s1_valid),
      .s1_item   (s1_item),
      .lut_data  (lut_data),
      .s1_take   (s1_take),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_x     (rsp_x),
      .rsp_y     (rsp_y),
      .rsp_pixel (rsp_pixel),
      .rsp_kind  (rsp_tuser),
      .rsp_last  (rsp_tlast)
   );

   assign rsp_tdata = {6'd0, rsp_pixel, rsp_y, rsp_x};

endmodule
